// ===== design/rsp_pkg.sv =====
package rsp_pkg;

  localparam int unsigned MaxPayload = 4096;
  localparam int unsigned LenW = 13;
  localparam int unsigned CntNeed = $clog2(MaxPayload + 1);
  localparam int unsigned CntW = (CntNeed > LenW) ? CntNeed : LenW;

  localparam logic [7:0] ChrDollar = 8'h24;
  localparam logic [7:0] ChrHash = 8'h23;
  localparam logic [7:0] ChrPlus = 8'h2B;
  localparam logic [7:0] ChrMinus = 8'h2D;
  localparam logic [7:0] ChrIntr = 8'h03;

  typedef enum logic [1:0] {
    PhOutside = 2'd0,
    PhPayload = 2'd1,
    PhHexHi = 2'd2,
    PhHexLo = 2'd3
  } rsp_phase_e;

  typedef enum logic [2:0] {
    EvNone = 3'd0,
    EvAck = 3'd1,
    EvNack = 3'd2,
    EvIntr = 3'd3,
    EvGood = 3'd4,
    EvBad = 3'd5,
    EvMalformed = 3'd6,
    EvTooLong = 3'd7
  } rsp_event_e;

  typedef struct packed {
    logic payload_valid;
    logic [7:0] payload_byte;
    rsp_event_e event_code;
    logic [LenW-1:0] payload_length;
    logic [7:0] sum_computed;
  } rsp_result_t;

  // Bit 4 of the result is set when the character is not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c inside {[8'h30:8'h39]}) begin
      v = {1'b0, 4'(c - 8'h30)};
    end else if (c inside {[8'h61:8'h66]}) begin
      v = {1'b0, 4'(c - 8'h57)};
    end else if (c inside {[8'h41:8'h46]}) begin
      v = {1'b0, 4'(c - 8'h37)};
    end
    return v;
  endfunction

endpackage

// ===== design/rsp_packet_deframer_unit.sv =====
// Channel  | Direction | Signals          | Contents
// s_axis   | in        | tvalid/tready    | tdata[7:0] rx_byte
// m_axis   | out       | tvalid/tready    | tdata: payload_byte, payload_length, sum_computed
//          |           |                  | tuser: payload_valid, event_code
//
// While s_axis_tready_o is high one item is taken per cycle, and each item gives exactly one result item.
// A result passes through the input register and then the result register, with
// the deframer state updated as the item moves between them.
// Reset clears the phase, the running sum, the count and both valid flags at once.
// While m_axis_tready_i is low the result holds, one more item waits in the input
// register, and s_axis_tready_o drops only when both are full.
module rsp_packet_deframer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // [7:0] payload_byte, [20:8] payload_length,
                                       // [28:21] sum_computed, [31:29] zero
  output logic [3:0]  m_axis_tuser_o   // [0] payload_valid, [3:1] event_code
);
  import rsp_pkg::*;

  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        step;
  rsp_result_t step_res;
  rsp_result_t out_res;

  rsp_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .data_i  (s_axis_tdata_i),
    .valid_o (in_valid),
    .ready_i (in_ready),
    .data_o  (in_byte)
  );

  assign step = in_valid && in_ready;

  rsp_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .rx_byte_i (in_byte),
    .result_o  (step_res)
  );

  rsp_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid),
    .ready_o  (in_ready),
    .result_i (step_res),
    .valid_o  (m_axis_tvalid_o),
    .ready_i  (m_axis_tready_i),
    .result_o (out_res)
  );

  assign m_axis_tdata_o = {3'b000, out_res.sum_computed, out_res.payload_length,
                           out_res.payload_byte};
  assign m_axis_tuser_o = {out_res.event_code, out_res.payload_valid};

endmodule

// ===== design/rsp_in_stage.sv =====
module rsp_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic [7:0] data_i,
  output logic       valid_o,
  input  logic       ready_i,
  output logic [7:0] data_o
);

  logic       valid_q, valid_d;
  logic [7:0] data_q, data_d;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    data_d = data_q;
    if (ready_o) begin
      valid_d = valid_i;
      data_d = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o = data_q;

endmodule

// ===== design/rsp_core.sv =====
module rsp_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          rx_byte_i,
  output rsp_pkg::rsp_result_t result_o
);
  import rsp_pkg::*;

  rsp_phase_e      phase_q, phase_d;
  logic [7:0]      sum_q, sum_d;
  logic [3:0]      hi_q, hi_d;
  logic            herr_q, herr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic [4:0]  hv;
  logic        herr_n;
  logic [7:0]  rx_sum;
  logic        done;
  rsp_result_t res;

  always_comb begin
    phase_d = phase_q;
    sum_d = sum_q;
    hi_d = hi_q;
    herr_d = herr_q;
    cnt_d = cnt_q;
    done = 1'b0;
    hv = hex_value(rx_byte_i);
    herr_n = herr_q | hv[4];
    rx_sum = herr_n ? 8'h00 : {hi_q, hv[3:0]};
    res = '0;
    res.event_code = EvNone;

    case (phase_q)
      PhOutside: begin
        if (rx_byte_i == ChrPlus) begin
          res.event_code = EvAck;
        end else if (rx_byte_i == ChrMinus) begin
          res.event_code = EvNack;
        end else if (rx_byte_i == ChrIntr) begin
          res.event_code = EvIntr;
        end else if (rx_byte_i == ChrDollar) begin
          phase_d = PhPayload;
          sum_d = '0;
          cnt_d = '0;
          herr_d = 1'b0;
          hi_d = '0;
        end else begin
          res.event_code = EvMalformed;
        end
      end
      PhPayload: begin
        if (rx_byte_i == ChrHash) begin
          phase_d = PhHexHi;
        end else if (cnt_q >= CntW'(MaxPayload)) begin
          res.event_code = EvTooLong;
          done = 1'b1;
        end else begin
          res.payload_valid = 1'b1;
          res.payload_byte = rx_byte_i;
          sum_d = sum_q + rx_byte_i;
          cnt_d = cnt_q + CntW'(1);
        end
      end
      PhHexHi: begin
        if (hv[4]) begin
          herr_d = 1'b1;
        end else begin
          hi_d = hv[3:0];
        end
        phase_d = PhHexLo;
      end
      PhHexLo: begin
        herr_d = herr_n;
        res.event_code = (rx_sum == sum_q) ? EvGood : EvBad;
        done = 1'b1;
      end
      default: begin
        phase_d = PhOutside;
      end
    endcase

    res.payload_length = cnt_d[LenW-1:0];
    res.sum_computed = sum_d;

    if (done) begin
      phase_d = PhOutside;
      sum_d = '0;
      cnt_d = '0;
      hi_d = '0;
      herr_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhOutside;
      sum_q <= '0;
      hi_q <= '0;
      herr_q <= 1'b0;
      cnt_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      sum_q <= sum_d;
      hi_q <= hi_d;
      herr_q <= herr_d;
      cnt_q <= cnt_d;
    end
  end

  assign result_o = res;

endmodule

// ===== design/rsp_out_stage.sv =====
module rsp_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  rsp_pkg::rsp_result_t result_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output rsp_pkg::rsp_result_t result_o
);
  import rsp_pkg::*;

  logic        valid_q, valid_d;
  rsp_result_t result_q, result_d;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    result_d = result_q;
    if (ready_o) begin
      valid_d = valid_i;
      result_d = result_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign valid_o = valid_q;
  assign result_o = result_q;

endmodule

// ===== design/rsp_checker.sv =====
module rsp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [7:0]  s_axis_tdata_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic [3:0]  m_axis_tuser_o
);
  import rsp_pkg::*;

  logic [2:0] ev;
  logic       pv;

  assign ev = m_axis_tuser_o[3:1];
  assign pv = m_axis_tuser_o[0];

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // A forwarded payload byte never carries an event.
  a_payload_no_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && pv |-> ev == EvNone && m_axis_tdata_o[20:8] != '0)
    else $error("payload byte with event or zero length");

  // Events outside a packet report no length and no sum.
  a_outside_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (ev == EvAck || ev == EvNack || ev == EvIntr || ev == EvMalformed)
      |-> m_axis_tdata_o[28:8] == '0 && !pv)
    else $error("outside event with packet data");

  // An accepted item with a free result register shows a result once it has passed the input and result registers.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && m_axis_tready_i ##1 m_axis_tready_i
      |=> m_axis_tvalid_o)
    else $error("result missing after accept");

  // Unused data bits of the result stay zero.
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[31:29] == 3'b000 && (pv || m_axis_tdata_o[7:0] == '0))
    else $error("padding or idle byte not zero");

endmodule

bind rsp_packet_deframer_unit rsp_checker u_rsp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
